// ===== src/hds_pkg.sv =====
// Package for the heat diffusion stencil: widths, cell kinds, register indexes,
// and the structs passed between the front end, the queue and the back end.
// No dependencies.
package hds_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MIN_WIDTH   = 3;
  localparam int TEMP_W      = 22;
  localparam int KIND_W      = 2;
  localparam int GRID_W      = 7;
  localparam int GAIN_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int ENERGY_W    = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 22;

  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W       = (GRID_W > WIDTH_W) ? GRID_W : WIDTH_W;
  localparam int ADDR_W      = COL_W + 1;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  localparam int DIFF_W      = TEMP_W + 3;
  localparam int PROD_W      = DIFF_W + GAIN_W + 1;
  localparam int SUM_W       = PROD_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W   = ((TEMP_W + 7) / 8) * 8;
  localparam int IN_USER_W   = KIND_W + 1;
  localparam int OUT_FIELD_W = TEMP_W + ENERGY_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_CENTRAL = 2'd1,
    KIND_BORDER  = 2'd2,
    KIND_DRILL   = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_X_GAIN      = 2'd1,
    REG_Y_GAIN      = 2'd2,
    REG_DRILL_TEMP  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_width;
    logic [GAIN_W-1:0] x_gain;
    logic [GAIN_W-1:0] y_gain;
    logic [TEMP_W-1:0] drill_temperature;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [TEMP_W-1:0] temp;
  } store_word_t;

  typedef struct packed {
    logic [TEMP_W-1:0] center;
    logic [TEMP_W-1:0] top;
    logic [TEMP_W-1:0] left;
    logic [TEMP_W-1:0] right;
    logic [TEMP_W-1:0] bottom;
    logic              compute;
  } stencil_t;

endpackage

// ===== src/heat_diffusion_stencil.sv =====
// Top level of the heat diffusion stencil: configuration registers, port packing,
// and the front end, queue and back end. Depends on hds_pkg, hds_front,
// hds_queue and hds_back.
//
//   channel   direction  fields
//   s_*       in         cell temperature, cell kind, frame start
//   m_*       out        temperature, energy, updated flag
//   cfg_*     in         grid width, x gain, y gain, drill temperature
//
// One word is accepted per cycle while the input is not stalled; the line store is two copies of a one-write,
// two-read memory, so all four neighbor reads fit in the accepting cycle.
// Once the cell of the row below is accepted, a result passes the front registers, the queue and the back pipeline.
// Reset clears counters and handshake state and loads the configuration defaults; the line store is not cleared.
// The input stalls only when the four-entry queue is full and the front register
// still holds a word; the back pipeline stalls on the output ready.
module heat_diffusion_stencil
  import hds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // cell_temperature, zero padding
  input  logic [IN_USER_W-1:0]   s_tuser,   // cell_kind, frame_start
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // out_temperature, energy, zero padding
  output logic [OUT_USER_W-1:0]  m_tuser,   // updated
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t                cfg;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  stencil_t            push_data, pop_data;
  logic [TEMP_W-1:0]   out_temperature;
  logic [ENERGY_W-1:0] out_energy;
  logic                out_updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width        <= GRID_W'(64);
      cfg.x_gain            <= GAIN_W'(16384);
      cfg.y_gain            <= GAIN_W'(16384);
      cfg.drill_temperature <= TEMP_W'(69926);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_GRID_WIDTH: cfg.grid_width        <= cfg_wdata[GRID_W-1:0];
        REG_X_GAIN:     cfg.x_gain            <= cfg_wdata[GAIN_W-1:0];
        REG_Y_GAIN:     cfg.y_gain            <= cfg_wdata[GAIN_W-1:0];
        REG_DRILL_TEMP: cfg.drill_temperature <= cfg_wdata[TEMP_W-1:0];
        default:        cfg                   <= cfg;
      endcase
    end
  end

  hds_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_temperature (s_tdata[TEMP_W-1:0]),
    .in_kind        (kind_t'(s_tuser[KIND_W-1:0])),
    .in_frame_start (s_tuser[KIND_W]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  hds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hds_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_temperature (out_temperature),
    .out_energy      (out_energy),
    .out_updated     (out_updated)
  );

  assign m_tdata = {(OUT_DATA_W - OUT_FIELD_W)'(0), out_energy, out_temperature};
  assign m_tuser = out_updated;

endmodule

// ===== src/hds_front.sv =====
// Front end: accepts cells, tracks column, row and bank, keeps the two-row line
// store in two copies and gathers the five stencil operands for each result.
// Depends on hds_pkg.
module hds_front
  import hds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TEMP_W-1:0] in_temperature,
  input  kind_t             in_kind,
  input  logic              in_frame_start,
  output logic              push_valid,
  input  logic              push_ready,
  output stencil_t          push_data
);

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [1:0]        rows_seen, rows_seen_next;
  logic              bank, bank_next;

  logic [COL_W-1:0]  col_base, col;
  logic [1:0]        rows_base;
  logic              bank_base;
  logic [CMP_W-1:0]  grid_ext, width_eff, col_ext, col_inc;
  logic              last_col;
  logic              accept;
  store_word_t       wr_word;
  logic [ADDR_W-1:0] cur_addr, ctr_addr, left_addr, right_addr;

  store_word_t       store_a [STORE_DEPTH];
  store_word_t       store_b [STORE_DEPTH];
  store_word_t       rd_left, rd_right, rd_center, rd_top;

  logic              f_valid;
  logic              f_top_ok, f_col_zero, f_right_ok;
  logic [TEMP_W-1:0] f_bottom;

  assign in_ready = !f_valid || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_base  = in_frame_start ? '0 : column_count;
    rows_base = in_frame_start ? 2'd0 : rows_seen;
    bank_base = in_frame_start ? 1'b0 : bank;

    grid_ext = CMP_W'(cfg.grid_width);
    if (grid_ext < CMP_W'(MIN_WIDTH)) begin
      width_eff = CMP_W'(MIN_WIDTH);
    end else if (grid_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = grid_ext;
    end

    col_ext = CMP_W'(col_base);
    if (col_ext >= width_eff) begin
      col = COL_W'(width_eff - CMP_W'(1));
    end else begin
      col = col_base;
    end
    col_inc  = CMP_W'(col) + CMP_W'(1);
    last_col = col_inc >= width_eff;

    wr_word.kind = in_kind;
    wr_word.temp = (in_kind == KIND_DRILL) ? cfg.drill_temperature : in_temperature;

    cur_addr   = {bank_base, col};
    ctr_addr   = {~bank_base, col};
    left_addr  = {~bank_base, COL_W'(col - 1'b1)};
    right_addr = {~bank_base, COL_W'(col + 1'b1)};
  end

  always_comb begin
    if (last_col) begin
      column_count_next = '0;
      rows_seen_next    = (rows_base < 2'd2) ? rows_base + 2'd1 : rows_base;
      bank_next         = ~bank_base;
    end else begin
      column_count_next = COL_W'(col_inc);
      rows_seen_next    = rows_base;
      bank_next         = bank_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_seen    <= 2'd0;
      bank         <= 1'b0;
      f_valid      <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        rows_seen    <= rows_seen_next;
        bank         <= bank_next;
        f_valid      <= rows_base != 2'd0;
      end else if (push_ready) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_top_ok   <= rows_base == 2'd2;
      f_col_zero <= col == '0;
      f_right_ok <= !last_col;
      f_bottom   <= wr_word.temp;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_left            <= store_a[left_addr];
      rd_right           <= store_a[right_addr];
      store_a[cur_addr]  <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_center          <= store_b[ctr_addr];
      rd_top             <= store_b[cur_addr];
      store_b[cur_addr]  <= wr_word;
    end
  end

  assign push_valid = f_valid;

  always_comb begin
    push_data.center  = rd_center.temp;
    push_data.top     = f_top_ok ? rd_top.temp : rd_center.temp;
    push_data.left    = (rd_center.kind == KIND_CENTRAL || f_col_zero) ?
                        rd_center.temp : rd_left.temp;
    push_data.right   = f_right_ok ? rd_right.temp : rd_center.temp;
    push_data.bottom  = f_bottom;
    push_data.compute = (rd_center.kind == KIND_NORMAL) ||
                        (rd_center.kind == KIND_CENTRAL);
  end

endmodule

// ===== src/hds_queue.sv =====
// Short first-in first-out queue of stencil operand sets between front and back end.
// Depends on hds_pkg.
module hds_queue
  import hds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  stencil_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output stencil_t pop_data
);

  stencil_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push, pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/hds_back.sv =====
// Back end: three-stage pipeline forming the second differences, the gain
// products, and the floored, saturated energy in the output register.
// Depends on hds_pkg.
module hds_back
  import hds_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  stencil_t            pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TEMP_W-1:0]   out_temperature,
  output logic [ENERGY_W-1:0] out_energy,
  output logic                out_updated
);

  localparam logic signed [SUM_W-1:0] E_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] E_MIN = -E_MAX - SUM_W'(1);

  logic                     v1, v2;
  logic                     en1, en2, en_o;
  logic signed [DIFF_W-1:0] dx, dy, s1_dx, s1_dy;
  logic [TEMP_W-1:0]        s1_temp, s2_temp;
  logic                     s1_compute, s2_compute;
  logic signed [PROD_W-1:0] s2_px, s2_py;
  logic signed [SUM_W-1:0]  sum, shifted, sat;

  assign en_o      = !out_valid || out_ready;
  assign en2       = !v2 || en_o;
  assign en1       = !v1 || en2;
  assign pop_ready = en1;

  always_comb begin
    dx = $signed(DIFF_W'(pop_data.left) + DIFF_W'(pop_data.right)
                 - (DIFF_W'(pop_data.center) << 1));
    dy = $signed(DIFF_W'(pop_data.top) + DIFF_W'(pop_data.bottom)
                 - (DIFF_W'(pop_data.center) << 1));
    sum     = SUM_W'(s2_px) + SUM_W'(s2_py);
    shifted = sum >>> FRAC_W;
    if (shifted > E_MAX) begin
      sat = E_MAX;
    end else if (shifted < E_MIN) begin
      sat = E_MIN;
    end else begin
      sat = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pop_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_o) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx      <= dx;
      s1_dy      <= dy;
      s1_temp    <= pop_data.center;
      s1_compute <= pop_data.compute;
    end
    if (en2) begin
      s2_px      <= $signed({1'b0, cfg.x_gain}) * s1_dx;
      s2_py      <= $signed({1'b0, cfg.y_gain}) * s1_dy;
      s2_temp    <= s1_temp;
      s2_compute <= s1_compute;
    end
    if (en_o) begin
      out_temperature <= s2_temp;
      out_energy      <= s2_compute ? ENERGY_W'(sat) : '0;
      out_updated     <= s2_compute;
    end
  end

endmodule

// ===== src/hds_checker.sv =====
// Port-level checker for the heat diffusion stencil, bound to the top level.
// Depends only on the top level's ports.
module hds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_reset_state: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("handshake state not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_pass_energy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[53:22] == 32'd0)
    else $error("border or drill cell carries nonzero energy");

  a_energy_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[53:46] == 8'h00 || m_tdata[53:46] == 8'hff)
    else $error("energy outside the reachable range");

endmodule

bind heat_diffusion_stencil hds_checker u_hds_checker (.*);
